[sv/lcmpc_pkg.sv]
// Shared types and constants for the lcm pair counter.
`timescale 1ns / 1ps
package lcmpc_pkg;

  localparam int COUNT_W = 32;
  localparam int PROD_W  = 33;

  localparam logic [PROD_W-1:0]  PRODUCT_CAP = 33'h1_FFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic take_quot;
    logic next_divisor;
    logic fold_tail;
    logic capture;
  } lcmpc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sq_le_rem;
    logic rem_trivial;
    logic div_done;
    logic div_exact;
  } lcmpc_status_t;

endpackage

[sv/lcmpc_divider.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lcmpc_divider #(
  parameter int VALUE_BITS = 40,
  parameter int DIV_W      = 22
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [DIV_W-1:0]      divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [DIV_W-1:0]      rem_o
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] quo_q;
  logic [DIV_W-1:0]      part_q, dsr_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, done_q;

  logic [DIV_W:0] trial, diff;
  logic           ge;

  always_comb begin
    trial = {part_q, quo_q[VALUE_BITS-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = trial >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      part_q <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(VALUE_BITS);
        quo_q  <= dividend_i;
        part_q <= '0;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        // shift in one dividend bit, subtract when it fits
        part_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_q  <= {quo_q[VALUE_BITS-2:0], ge};
        cnt_q  <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = part_q;

endmodule

[sv/lcmpc_datapath.sv]
// Datapath: remaining value, trial divisor and its square, exponent, running product.
`timescale 1ns / 1ps
module lcmpc_datapath #(
  parameter int VALUE_BITS = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [VALUE_BITS-1:0]         value_i,
  input  lcmpc_pkg::lcmpc_cmd_t         cmd_i,
  output lcmpc_pkg::lcmpc_status_t      status_o,
  output logic [lcmpc_pkg::COUNT_W-1:0] count_o
);
  import lcmpc_pkg::*;

  localparam int DIV_W = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_W  = 2 * DIV_W;
  localparam int EXP_W = $clog2(VALUE_BITS + 1);
  localparam int FAC_W = EXP_W + 1;
  localparam int MUL_W = PROD_W + FAC_W;

  logic [VALUE_BITS-1:0] rem_q;
  logic [DIV_W-1:0]      trial_q;
  logic [SQ_W-1:0]       sq_q;
  logic [EXP_W-1:0]      exp_q;
  logic [PROD_W-1:0]     prod_q;
  logic [COUNT_W-1:0]    count_q;

  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIV_W-1:0]      div_rem;

  logic [FAC_W-1:0]  factor;
  logic [MUL_W-1:0]  mul;
  logic [PROD_W-1:0] prod_fold;
  logic [PROD_W:0]   prod_inc;
  logic [PROD_W-1:0] half;
  logic [COUNT_W-1:0] count_d;

  lcmpc_divider #(
    .VALUE_BITS(VALUE_BITS),
    .DIV_W     (DIV_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(rem_q),
    .divisor_i (trial_q),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  always_comb begin
    // a lone leftover prime contributes 2*1+1
    factor    = cmd_i.fold_tail ? FAC_W'(3) : {exp_q, 1'b1};
    mul       = MUL_W'(prod_q) * MUL_W'(factor);
    prod_fold = (mul > MUL_W'(PRODUCT_CAP)) ? PRODUCT_CAP : mul[PROD_W-1:0];
    prod_inc  = {1'b0, prod_q} + (PROD_W + 1)'(1);
    half      = prod_inc[PROD_W:1];
    if (rem_q == '0) begin
      count_d = '0;
    end else if (half > PROD_W'(COUNT_MAX)) begin
      count_d = COUNT_MAX;
    end else begin
      count_d = half[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      trial_q <= DIV_W'(2);
      sq_q    <= SQ_W'(4);
      exp_q   <= '0;
      prod_q  <= PROD_W'(1);
      count_q <= '0;
    end else begin
      if (cmd_i.load) begin
        rem_q   <= value_i;
        trial_q <= DIV_W'(2);
        sq_q    <= SQ_W'(4);
        exp_q   <= '0;
        prod_q  <= PROD_W'(1);
      end
      if (cmd_i.take_quot) begin
        rem_q <= div_quot;
        exp_q <= exp_q + EXP_W'(1);
      end
      if (cmd_i.next_divisor) begin
        if (exp_q != '0) begin
          prod_q <= prod_fold;
        end
        exp_q   <= '0;
        trial_q <= trial_q + DIV_W'(1);
        // (d+1)^2 = d^2 + 2d + 1
        sq_q    <= sq_q + SQ_W'({trial_q, 1'b1});
      end
      if (cmd_i.fold_tail) begin
        prod_q <= prod_fold;
      end
      if (cmd_i.capture) begin
        count_q <= count_d;
      end
    end
  end

  assign status_o.sq_le_rem   = sq_q <= SQ_W'(rem_q);
  assign status_o.rem_trivial = rem_q[VALUE_BITS-1:1] == '0;
  assign status_o.div_done    = div_done;
  assign status_o.div_exact   = div_rem == '0;
  assign count_o              = count_q;

`ifndef SYNTHESIS
  a_exp_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_quot |-> exp_q != '1)
    else $error("exponent counter wraps");

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0 && !cmd_i.load) |=> rem_q != '0)
    else $error("remaining value dropped to zero");

  // repeated divisions by the same prime skip the square check
  a_divisor_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (trial_q >= DIV_W'(2) && rem_q != '0))
    else $error("division started with bad divisor");

  a_prod_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_q <= PRODUCT_CAP && prod_q != '0)
    else $error("running product out of range");
`endif

endmodule

[sv/lcmpc_ctrl.sv]
// Controller: sequences trial division and result hand-off.
`timescale 1ns / 1ps
module lcmpc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  lcmpc_pkg::lcmpc_status_t status_i,
  output lcmpc_pkg::lcmpc_cmd_t    cmd_o
);
  import lcmpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_START,
    S_DIV,
    S_TAIL,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.sq_le_rem) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          if (status_i.div_exact) begin
            // divide out again with the same divisor
            cmd_o.take_quot = 1'b1;
            state_d         = S_START;
          end else begin
            cmd_o.next_divisor = 1'b1;
            state_d            = S_CHECK;
          end
        end
      end
      S_TAIL: begin
        cmd_o.fold_tail = !status_i.rem_trivial;
        state_d         = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

[sv/lcm_pair_counter.sv]
// Top level: counts unordered pairs of positive integers with a given lcm.
//
// Input stream (s_axis_*): one beat carries target_value in the low VALUE_BITS
// bits of tdata; upper pad bits are ignored. Output stream (m_axis_*): one
// beat per input beat, pair_count in tdata[31:0]. Zero input yields 0.
// The value is factored by trial division d = 2, 3, ... while d*d does not
// exceed the remaining value; each test is one pass of a bit-serial divider
// sequenced by the controller. Inputs below 4 skip the divider.
// One item is in work at a time; s_axis_tready_o is high only while the
// block waits for a beat.
// The result sits in an output register, so a new item is taken and worked
// while the last result waits; a stalled receiver only blocks hand-off of
// the next finished result. Reset empties the output register and returns
// the block to waiting for input.
`timescale 1ns / 1ps
module lcm_pair_counter #(
  parameter int VALUE_BITS = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,  // target_value
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [lcmpc_pkg::COUNT_W-1:0]       m_axis_tdata_o   // pair_count
);
  import lcmpc_pkg::*;

  lcmpc_cmd_t    cmd;
  lcmpc_status_t status;

  lcmpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lcmpc_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (s_axis_tdata_i[VALUE_BITS-1:0]),
    .cmd_i   (cmd),
    .status_o(status),
    .count_o (m_axis_tdata_o)
  );

endmodule

[test/tb_lcm_pair_counter.sv]
// Self-checking testbench for lcm_pair_counter: streams values in and checks every pair count.
`timescale 1ns / 1ps
module tb_lcm_pair_counter;
  import lcmpc_pkg::*;

  localparam int VALUE_BITS = 40;
  localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
  localparam longint unsigned VALUE_TOP = 64'd1 << VALUE_BITS;
  localparam int STALL_PCT = 17;
  localparam int RANDOM_ITEMS = 100;
  localparam int DRAIN_CYCLES = 200;
  // Watchdog limit on quiet cycles; allows plenty of margin over the slowest value used.
  localparam int WATCHDOG_LIMIT = 400000;

  // Holds the pair counts still owed by the block, oldest first.
  class lcm_pair_board;
    bit [COUNT_W-1:0]    pair_counts_due[$];
    bit [VALUE_BITS-1:0] targets_due[$];

    function longint unsigned fold_exponent(longint unsigned prod, int unsigned e);
      longint unsigned f = 2 * e + 1;
      if (prod > PRODUCT_CAP / f) return PRODUCT_CAP;
      return prod * f;
    endfunction

    // Trial division, then (product of (2e+1) + 1) / 2 over the prime exponents.
    function bit [COUNT_W-1:0] lcm_pairs_of(bit [VALUE_BITS-1:0] target);
      longint unsigned rest = target;
      longint unsigned divisor = 2;
      longint unsigned prod = 1;
      longint unsigned answer;
      int unsigned e;
      if (target == 0) return '0;
      while (divisor <= rest / divisor) begin
        if (rest % divisor == 0) begin
          e = 0;
          while (rest % divisor == 0) begin
            e++;
            rest = rest / divisor;
          end
          prod = fold_exponent(prod, e);
        end
        divisor++;
      end
      if (rest != 1) prod = fold_exponent(prod, 1);
      answer = (prod + 1) / 2;
      if (answer > COUNT_MAX) answer = COUNT_MAX;
      return answer[COUNT_W-1:0];
    endfunction

    function void note_target(bit [VALUE_BITS-1:0] target);
      targets_due     = {targets_due, target};
      pair_counts_due = {pair_counts_due, lcm_pairs_of(target)};
    endfunction

    function bit check_count(bit [COUNT_W-1:0] got, output string why);
      bit [COUNT_W-1:0]    want;
      bit [VALUE_BITS-1:0] target;
      if (pair_counts_due.size() == 0) begin
        why = $sformatf("pair_count %0d with no input pending", got);
        return 1'b0;
      end
      want   = pair_counts_due.pop_front();
      target = targets_due.pop_front();
      if (got != want) begin
        why = $sformatf("target %0d: pair_count %0d, want %0d", target, got, want);
        return 1'b0;
      end
      why = "";
      return 1'b1;
    endfunction

    function int pending();
      return pair_counts_due.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni   = 1'b0;
  logic               s_tvalid = 1'b0;
  logic [TDATA_W-1:0] s_tdata  = '0;
  logic               s_tready;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [COUNT_W-1:0] m_tdata;

  lcm_pair_board board = new();
  int    mismatches   = 0;
  int    quiet_cycles = 0;
  bit    steady       = 1'b0;
  string why;

  lcm_pair_counter #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one value, with a random gap first, and hold it until the beat is taken.
  task automatic send_target(longint unsigned value);
    if (!steady && $urandom_range(0, 99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 60);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value[TDATA_W-1:0];
    do @(posedge clk_i); while (!s_tready);
    board.note_target(value[VALUE_BITS-1:0]);
  endtask

  // Hold off input until every owed count has come back.
  task automatic await_drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Receive side: check each result beat, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (!board.check_count(m_tdata, why)) report_mismatch(why);
      end
      m_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    longint unsigned directed[$] = '{
      64'd0,                    // no pairs at all
      64'd1,                    // no prime factors
      64'd2, 64'd3, 64'd4, 64'd12, 64'd36,
      64'd1 << 39,              // single prime, top bit
      VALUE_TOP - 1,            // all ones
      64'd720720, 64'd510510,
      64'd200560490130,         // product of the primes up to 31
      64'd847288609443,         // 3^25
      64'd1000000,
      64'd999983,               // large prime left as remainder
      64'd999983 << 20
    };
    longint unsigned value;
    int unsigned     factor;
    int              msb;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_target(directed[i]);
    await_drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= 40 && n < 70);
      if (n == 80) await_drain();
      if ($urandom_range(0, 99) < 15) begin
        value = $urandom_range(0, 65535);
      end else begin
        // Small factors and a modest cofactor keep trial division short.
        value = 1;
        repeat ($urandom_range(0, 8)) begin
          factor = $urandom_range(2, 97);
          if (value * factor < VALUE_TOP) value = value * factor;
        end
        if ($urandom_range(0, 1)) begin
          factor = $urandom_range(2, 10000);
          if (value * factor < VALUE_TOP) value = value * factor;
        end
        if ($urandom_range(0, 1)) begin
          msb = 0;
          for (int b = 0; b < VALUE_BITS; b++) if (value[b]) msb = b;
          value = value << $urandom_range(0, VALUE_BITS - 1 - msb);
        end
      end
      send_target(value);
    end

    await_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
